@@ src/mbg_pkg.sv @@
// Shared types and constants of the maze backtracker generator.
// Used by maze_backtracker_generator and its port checker; depends on nothing.
package mbg_pkg;

    // Field widths of the request and response words
    localparam int CMD_W   = 2;
    localparam int RAND_W  = 16;
    localparam int COORD_W = 5;
    localparam int EVENT_W = 3;
    localparam int DIR_W   = 2;
    localparam int WALLS_W = 4;

    // Configuration port
    localparam int CFG_W      = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [CFG_W-1:0] NUM_COLUMNS_RESET = 6'd16;
    localparam logic [CFG_W-1:0] NUM_ROWS_RESET    = 6'd16;

    // Bit positions inside a cell word: four walls and the visited mark
    localparam int WALL_LEFT    = 0;
    localparam int WALL_RIGHT   = 1;
    localparam int WALL_TOP     = 2;
    localparam int WALL_BOTTOM  = 3;
    localparam int CELL_VISITED = 4;
    localparam int CELL_W       = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESTART  = 2'd0,
        CMD_STEP     = 2'd1,
        CMD_READ     = 2'd2,
        CMD_READ_ALT = 2'd3
    } cmd_e;

    typedef enum logic [EVENT_W-1:0] {
        EV_CARVED       = 3'd0,
        EV_BACKTRACKED  = 3'd1,
        EV_FINISHED     = 3'd2,
        EV_DONE_ALREADY = 3'd3,
        EV_RESTARTED    = 3'd4,
        EV_READ_OK      = 3'd5,
        EV_READ_RANGE   = 3'd6
    } event_e;

    typedef enum logic [DIR_W-1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_e;

    typedef enum logic {
        REG_NUM_COLUMNS = 1'b0,
        REG_NUM_ROWS    = 1'b1
    } reg_e;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDATA,
        S_TOP,
        S_PROBE,
        S_LAST,
        S_DECIDE,
        S_CARVE_TOP,
        S_CARVE_NEXT,
        S_EMIT
    } state_e;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [RAND_W-1:0]  rand_value;
        logic [COORD_W-1:0] cell_column;
        logic [COORD_W-1:0] cell_row;
    } req_word_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [COORD_W-1:0] cur_column;
        logic [COORD_W-1:0] cur_row;
        logic [DIR_W-1:0]   direction;
        logic [WALLS_W-1:0] wall_bits;
    } rsp_word_t;

endpackage

@@ src/maze_backtracker_generator.sv @@
// Maze backtracker generator: sequencer, cell memory, path stack, config registers.
// Depends on mbg_pkg.
//
// Usage:
// - Request channel (req_valid/req_stall/req_data) takes one command word:
//   restart, one carving step, or a read of one cell's walls. Every request
//   gives exactly one response word on rsp_valid/rsp_stall/rsp_data.
// - Each request is worked on alone; req_stall stays high until it is done.
// - States: restart, read out of range or step after the finish go to S_EMIT;
//   read in range passes S_RDATA; step passes S_TOP, S_PROBE, S_LAST, S_DECIDE,
//   carve also S_CARVE_TOP, S_CARVE_NEXT. The cell memory's single read port
//   probes the four neighbors in turn, its single write port updates both cells.
// - After a restart response, sweep all MAX_COLUMNS*MAX_ROWS cell memory entries
//   (1024 by default), one entry per cycle, before the next word.
// - After reset the same sweep runs first; req_stall is high during it.
//   Configuration writes are taken at any time.
// - A response waits in the output register while rsp_stall is high; a new
//   request is still accepted, and its response waits until that one leaves.
// - APB registers: num_columns at 0, num_rows at 4, 6 bits each; pready is
//   always high.
module maze_backtracker_generator
    import mbg_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_ROWS    = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_word_t             req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_word_t             rsp_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int NCOL_W     = $clog2(MAX_COLUMNS + 1);
    localparam int NROW_W     = $clog2(MAX_ROWS + 1);
    localparam int ENTRY_W    = COL_W + ROW_W;

    // Storage address of a cell: column*MAX_ROWS + row
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        cell_addr = ADDR_W'(col) * ADDR_W'(MAX_ROWS) + ADDR_W'(row);
    endfunction

    // Residue of the random word mod 3 by folding base-4 digits
    function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] f;
        s = '0;
        for (int i = 0; i < RAND_W / 2; i++)
        begin
            s = s + 5'(v[2*i +: 2]);
        end
        f = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (f >= 3'd6)
        begin
            f = f - 3'd6;
        end
        else if (f >= 3'd3)
        begin
            f = f - 3'd3;
        end
        mod3 = f[1:0];
    endfunction

    // Wall removed on the cell carved from
    function automatic logic [WALLS_W-1:0] from_wall(input dir_e d);
        logic [WALLS_W-1:0] m;
        m = '0;
        unique case (d)
            DIR_RIGHT: m[WALL_RIGHT]  = 1'b1;
            DIR_LEFT:  m[WALL_LEFT]   = 1'b1;
            DIR_UP:    m[WALL_TOP]    = 1'b1;
            DIR_DOWN:  m[WALL_BOTTOM] = 1'b1;
        endcase
        from_wall = m;
    endfunction

    // Wall removed on the cell carved into
    function automatic logic [WALLS_W-1:0] into_wall(input dir_e d);
        logic [WALLS_W-1:0] m;
        m = '0;
        unique case (d)
            DIR_RIGHT: m[WALL_LEFT]   = 1'b1;
            DIR_LEFT:  m[WALL_RIGHT]  = 1'b1;
            DIR_UP:    m[WALL_BOTTOM] = 1'b1;
            DIR_DOWN:  m[WALL_TOP]    = 1'b1;
        endcase
        into_wall = m;
    endfunction

    // Control registers
    state_e               state_reg, state_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic                 finished_reg, finished_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [1:0]           probe_idx_reg, probe_idx_next;
    logic [CFG_W-1:0]     num_columns_reg, num_columns_next;
    logic [CFG_W-1:0]     num_rows_reg, num_rows_next;

    // Payload registers
    req_word_t            req_reg, req_next;
    rsp_word_t            res_reg, res_next;
    rsp_word_t            rsp_data_reg, rsp_data_next;
    logic [COL_W-1:0]     top_col_reg, top_col_next;
    logic [ROW_W-1:0]     top_row_reg, top_row_next;
    logic [WALLS_W-1:0]   top_walls_reg, top_walls_next;
    logic [3:0]           ok_reg, ok_next;
    logic [3:0]           cand_reg, cand_next;
    dir_e                 dir_reg, dir_next;

    // Memories
    logic [CELL_W-1:0]    cell_mem [CELL_COUNT];
    logic [CELL_W-1:0]    cell_q;
    logic                 cell_we;
    logic [ADDR_W-1:0]    cell_waddr;
    logic [CELL_W-1:0]    cell_wdata;
    logic [ADDR_W-1:0]    cell_raddr;
    logic [ENTRY_W-1:0]   stk_mem [CELL_COUNT];
    logic [ENTRY_W-1:0]   stk_q;
    logic                 stk_we;
    logic [ADDR_W-1:0]    stk_waddr;
    logic [ENTRY_W-1:0]   stk_wdata;
    logic [DEPTH_W-1:0]   depth_less;

    // Working values
    logic                 accept;
    logic [NCOL_W-1:0]    cols;
    logic [NROW_W-1:0]    rows;
    logic                 read_in_range;
    logic                 step_blocked;
    dir_e                 nb_dir;
    logic [COL_W-1:0]     nb_col;
    logic [ROW_W-1:0]     nb_row;
    logic                 nb_ok;
    logic [2:0]           cand_count;
    logic [1:0]           pick;
    dir_e                 pick_dir;
    logic                 carve;
    logic [1:0]           cap_idx;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign pready    = 1'b1;
    assign cap_idx   = probe_idx_reg - 2'd1;

    // Clamp the configured grid size to 2..MAX
    always_comb
    begin
        if (32'(num_columns_reg) < 32'd2)
        begin
            cols = NCOL_W'(2);
        end
        else if (32'(num_columns_reg) > 32'(MAX_COLUMNS))
        begin
            cols = NCOL_W'(MAX_COLUMNS);
        end
        else
        begin
            cols = NCOL_W'(num_columns_reg);
        end
        if (32'(num_rows_reg) < 32'd2)
        begin
            rows = NROW_W'(2);
        end
        else if (32'(num_rows_reg) > 32'(MAX_ROWS))
        begin
            rows = NROW_W'(MAX_ROWS);
        end
        else
        begin
            rows = NROW_W'(num_rows_reg);
        end
    end

    assign read_in_range = (32'(req_data.cell_column) < 32'(cols))
                        && (32'(req_data.cell_row) < 32'(rows));
    assign step_blocked  = finished_reg || (depth_reg == '0);

    // Shared neighbor unit: coordinate of the cell next to the top, and bound check
    assign nb_dir = (state_reg == S_PROBE) ? dir_e'(probe_idx_reg) : dir_reg;

    always_comb
    begin
        nb_col = top_col_reg;
        nb_row = top_row_reg;
        nb_ok  = 1'b0;
        unique case (nb_dir)
            DIR_RIGHT:
            begin
                nb_col = top_col_reg + COL_W'(1);
                nb_ok  = (32'(top_col_reg) + 32'd1 < 32'(cols))
                      && (32'(top_row_reg) < 32'(rows));
            end
            DIR_LEFT:
            begin
                nb_col = top_col_reg - COL_W'(1);
                nb_ok  = (top_col_reg != '0)
                      && (32'(top_col_reg) - 32'd1 < 32'(cols))
                      && (32'(top_row_reg) < 32'(rows));
            end
            DIR_UP:
            begin
                nb_row = top_row_reg - ROW_W'(1);
                nb_ok  = (top_row_reg != '0)
                      && (32'(top_row_reg) - 32'd1 < 32'(rows))
                      && (32'(top_col_reg) < 32'(cols));
            end
            DIR_DOWN:
            begin
                nb_row = top_row_reg + ROW_W'(1);
                nb_ok  = (32'(top_row_reg) + 32'd1 < 32'(rows))
                      && (32'(top_col_reg) < 32'(cols));
            end
        endcase
    end

    // Choose the candidate given by the random word mod the candidate count
    always_comb
    begin
        logic [1:0] seen;
        logic       found;
        seen       = '0;
        found      = 1'b0;
        pick_dir   = DIR_RIGHT;
        cand_count = 3'($countones(cand_reg));
        case (cand_count)
            3'd2:    pick = {1'b0, req_reg.rand_value[0]};
            3'd3:    pick = mod3(req_reg.rand_value);
            3'd4:    pick = req_reg.rand_value[1:0];
            default: pick = 2'd0;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            if (cand_reg[i] && !found)
            begin
                if (seen == pick)
                begin
                    pick_dir = dir_e'(2'(i));
                    found    = 1'b1;
                end
                else
                begin
                    seen = seen + 2'd1;
                end
            end
        end
        carve = (cand_count != '0) && (depth_reg < DEPTH_W'(CELL_COUNT));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_data.cmd) inside
                        CMD_RESTART:            state_next = S_EMIT;
                        CMD_STEP:               state_next = step_blocked ? S_EMIT : S_TOP;
                        CMD_READ, CMD_READ_ALT: state_next = read_in_range ? S_RDATA : S_EMIT;
                    endcase
                end
            end
            S_RDATA:      state_next = S_EMIT;
            S_TOP:        state_next = S_PROBE;
            S_PROBE:
            begin
                if (probe_idx_reg == 2'd3)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:       state_next = S_DECIDE;
            S_DECIDE:     state_next = carve ? S_CARVE_TOP : S_EMIT;
            S_CARVE_TOP:  state_next = S_CARVE_NEXT;
            S_CARVE_NEXT: state_next = S_EMIT;
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = (req_reg.cmd == CMD_RESTART) ? S_CLEAR : S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // Memory controls
    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = cell_addr(top_col_reg, top_row_reg);
        cell_wdata = {1'b1, top_walls_reg & ~from_wall(dir_reg)};
        cell_raddr = cell_addr(nb_col, nb_row);
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[ADDR_W-1:0];
        stk_wdata  = {nb_col, nb_row};
        unique case (state_reg)
            S_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_addr_reg;
                cell_wdata = {(clr_addr_reg == '0), {WALLS_W{1'b1}}};
                stk_we     = (clr_addr_reg == '0);
                stk_waddr  = '0;
                stk_wdata  = '0;
            end
            S_IDLE:
            begin
                cell_raddr = cell_addr(COL_W'(req_data.cell_column), ROW_W'(req_data.cell_row));
            end
            S_TOP:
            begin
                cell_raddr = cell_addr(stk_q[ENTRY_W-1 -: COL_W], stk_q[ROW_W-1:0]);
            end
            S_CARVE_TOP:
            begin
                cell_we = 1'b1;
            end
            S_CARVE_NEXT:
            begin
                cell_we    = 1'b1;
                cell_waddr = cell_addr(nb_col, nb_row);
                cell_wdata = {1'b1, {WALLS_W{1'b1}} & ~into_wall(dir_reg)};
                stk_we     = 1'b1;
            end
            default:
            begin
                cell_we = 1'b0;
            end
        endcase
    end

    // Cell memory: visited mark and walls, one write and one read port
    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_q <= cell_mem[cell_raddr];
    end

    // Path stack: top entry is read every cycle
    assign depth_less = depth_reg - DEPTH_W'(1);

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q <= stk_mem[depth_less[ADDR_W-1:0]];
    end

    // Datapath next values
    always_comb
    begin
        depth_next       = depth_reg;
        finished_next    = finished_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_data_next    = rsp_data_reg;
        clr_addr_next    = clr_addr_reg;
        probe_idx_next   = probe_idx_reg;
        num_columns_next = num_columns_reg;
        num_rows_next    = num_rows_reg;
        req_next         = req_reg;
        res_next         = res_reg;
        top_col_next     = top_col_reg;
        top_row_next     = top_row_reg;
        top_walls_next   = top_walls_reg;
        ok_next          = ok_reg;
        cand_next        = cand_reg;
        dir_next         = dir_reg;

        // Configuration write
        if (psel && penable && pwrite)
        begin
            unique case (reg_e'(paddr[2]))
                REG_NUM_COLUMNS: num_columns_next = pwdata[CFG_W-1:0];
                REG_NUM_ROWS:    num_rows_next    = pwdata[CFG_W-1:0];
            endcase
        end

        // Drop the response once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                depth_next    = DEPTH_W'(1);
                finished_next = 1'b0;
                clr_addr_next = (clr_addr_reg == ADDR_W'(CELL_COUNT - 1))
                              ? '0 : clr_addr_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next       = req_data;
                    res_next       = '0;
                    probe_idx_next = '0;
                    unique case (req_data.cmd) inside
                        CMD_RESTART:
                        begin
                            res_next.event_res = EV_RESTARTED;
                        end
                        CMD_STEP:
                        begin
                            res_next.event_res = EV_DONE_ALREADY;
                        end
                        CMD_READ, CMD_READ_ALT:
                        begin
                            res_next.cur_column = req_data.cell_column;
                            res_next.cur_row    = req_data.cell_row;
                            res_next.event_res  = read_in_range ? EV_READ_OK : EV_READ_RANGE;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                res_next.wall_bits = cell_q[WALLS_W-1:0];
            end
            S_TOP:
            begin
                top_col_next = stk_q[ENTRY_W-1 -: COL_W];
                top_row_next = stk_q[ROW_W-1:0];
            end
            S_PROBE:
            begin
                // Issue one neighbor probe, capture the previous one
                ok_next[probe_idx_reg] = nb_ok;
                if (probe_idx_reg == 2'd0)
                begin
                    top_walls_next = cell_q[WALLS_W-1:0];
                end
                else
                begin
                    cand_next[cap_idx] = ok_reg[cap_idx] && !cell_q[CELL_VISITED];
                end
                probe_idx_next = probe_idx_reg + 2'd1;
            end
            S_LAST:
            begin
                cand_next[cap_idx] = ok_reg[cap_idx] && !cell_q[CELL_VISITED];
            end
            S_DECIDE:
            begin
                res_next.cur_column = COORD_W'(top_col_reg);
                res_next.cur_row    = COORD_W'(top_row_reg);
                if (carve)
                begin
                    dir_next           = pick_dir;
                    res_next.event_res = EV_CARVED;
                    res_next.direction = pick_dir;
                end
                else
                begin
                    depth_next = depth_less;
                    if (depth_less == '0)
                    begin
                        finished_next      = 1'b1;
                        res_next.event_res = EV_FINISHED;
                    end
                    else
                    begin
                        res_next.event_res = EV_BACKTRACKED;
                    end
                end
            end
            S_CARVE_NEXT:
            begin
                depth_next = depth_reg + DEPTH_W'(1);
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                end
            end
            default:
            begin
                depth_next = depth_reg;
            end
        endcase
    end

    // Register read
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'd0)
        begin
            unique case (reg_e'(paddr[2]))
                REG_NUM_COLUMNS: prdata = APB_DATA_W'(num_columns_reg);
                REG_NUM_ROWS:    prdata = APB_DATA_W'(num_rows_reg);
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            depth_reg       <= DEPTH_W'(1);
            finished_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            clr_addr_reg    <= '0;
            probe_idx_reg   <= '0;
            num_columns_reg <= NUM_COLUMNS_RESET;
            num_rows_reg    <= NUM_ROWS_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            depth_reg       <= depth_next;
            finished_reg    <= finished_next;
            rsp_valid_reg   <= rsp_valid_next;
            clr_addr_reg    <= clr_addr_next;
            probe_idx_reg   <= probe_idx_next;
            num_columns_reg <= num_columns_next;
            num_rows_reg    <= num_rows_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        rsp_data_reg  <= rsp_data_next;
        top_col_reg   <= top_col_next;
        top_row_reg   <= top_row_next;
        top_walls_reg <= top_walls_next;
        ok_reg        <= ok_next;
        cand_reg      <= cand_next;
        dir_reg       <= dir_next;
    end

endmodule

@@ src/mbg_checker.sv @@
// Port-level checks of the maze backtracker generator, bound to its top level.
// Depends on mbg_pkg and maze_backtracker_generator.
module mbg_checker
    import mbg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input rsp_word_t rsp_data,
    input logic      rsp_valid,
    input logic      rsp_stall
);

    // Hold a stalled response word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("response word changed while stalled");

    // Work on one request word at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken in back-to-back cycles");

    // Report a direction only for a carve
    a_dir_only_on_carve: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.event_res != EV_CARVED) |-> rsp_data.direction == DIR_RIGHT)
        else $error("direction set on a word that is not a carve");

    // Report walls only for a read in range
    a_walls_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.event_res != EV_READ_OK) |-> rsp_data.wall_bits == '0)
        else $error("wall bits set on a word that is not a read");

endmodule

bind maze_backtracker_generator mbg_checker u_mbg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
);
